[sv/wst_pkg.sv]
package wst_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_LOAD_A,
        ST_WALK_A,
        ST_LOAD_B,
        ST_WALK_B,
        ST_WALK_FULL
    } state_t;

    typedef enum logic [1:0] {
        RECT_COLS,
        RECT_ROWS,
        RECT_FULL
    } rect_sel_t;

    typedef struct packed {
        logic      idle;
        logic      load;
        rect_sel_t sel;
        logic      walking;
        logic      final_rect;
    } ctrl_t;

endpackage

[sv/wst_walk.sv]
// Rectangle walker: outer/inner position counters sharing one 16-bit incrementer.
module wst_walk #(
    parameter int CW = 4
) (
    input  logic          aclk,
    input  logic          load,
    input  logic          step,
    input  logic          x_outer,
    input  logic [15:0]   outer_start,
    input  logic [CW-1:0] outer_len,
    input  logic [15:0]   inner_start,
    input  logic [CW-1:0] inner_len,
    output logic [15:0]   tile_x,
    output logic [15:0]   tile_z,
    output logic          rect_end
);

    logic [15:0]   out_pos_reg, out_pos_next;
    logic [15:0]   in_pos_reg, in_pos_next;
    logic [15:0]   in_base_reg, in_base_next;
    logic [CW-1:0] in_cnt_reg, in_cnt_next;
    logic [CW-1:0] out_cnt_reg, out_cnt_next;
    logic [CW-1:0] in_len_reg, in_len_next;
    logic [CW-1:0] out_len_reg, out_len_next;
    logic          x_outer_reg, x_outer_next;

    logic          inner_wrap;
    logic [15:0]   inc_src;
    logic [15:0]   inc_res;

    always_comb begin
        inner_wrap = (in_cnt_reg + CW'(1)) == in_len_reg;
        rect_end   = inner_wrap && ((out_cnt_reg + CW'(1)) == out_len_reg);
        // only one axis advances per step, so one incrementer serves both
        inc_src    = inner_wrap ? out_pos_reg : in_pos_reg;
        inc_res    = inc_src + 16'd1;
        tile_x     = x_outer_reg ? out_pos_reg : in_pos_reg;
        tile_z     = x_outer_reg ? in_pos_reg : out_pos_reg;
    end

    always_comb begin
        out_pos_next = out_pos_reg;
        in_pos_next  = in_pos_reg;
        in_base_next = in_base_reg;
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        in_len_next  = in_len_reg;
        out_len_next = out_len_reg;
        x_outer_next = x_outer_reg;
        if (load) begin
            out_pos_next = outer_start;
            in_pos_next  = inner_start;
            in_base_next = inner_start;
            in_cnt_next  = '0;
            out_cnt_next = '0;
            in_len_next  = inner_len;
            out_len_next = outer_len;
            x_outer_next = x_outer;
        end else if (step) begin
            if (inner_wrap) begin
                out_pos_next = inc_res;
                in_pos_next  = in_base_reg;
                in_cnt_next  = '0;
                out_cnt_next = out_cnt_reg + CW'(1);
            end else begin
                in_pos_next  = inc_res;
                in_cnt_next  = in_cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_pos_reg <= out_pos_next;
        in_pos_reg  <= in_pos_next;
        in_base_reg <= in_base_next;
        in_cnt_reg  <= in_cnt_next;
        out_cnt_reg <= out_cnt_next;
        in_len_reg  <= in_len_next;
        out_len_reg <= out_len_next;
        x_outer_reg <= x_outer_next;
    end

endmodule

[sv/wst_seq.sv]
module wst_seq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic          near,
    input  logic          dx_zero,
    input  logic          dz_zero,
    input  logic          step,
    input  logic          rect_end,
    output wst_pkg::ctrl_t ctrl
);

    wst_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wst_pkg::ST_IDLE: begin
                if (start) state_next = wst_pkg::ST_PLAN;
            end
            wst_pkg::ST_PLAN: begin
                state_next = wst_pkg::ST_LOAD_A;
            end
            wst_pkg::ST_LOAD_A: begin
                if (!near)         state_next = wst_pkg::ST_WALK_FULL;
                else if (!dx_zero) state_next = wst_pkg::ST_WALK_A;
                else if (!dz_zero) state_next = wst_pkg::ST_WALK_B;
                else               state_next = wst_pkg::ST_IDLE;
            end
            wst_pkg::ST_WALK_A: begin
                if (step && rect_end)
                    state_next = dz_zero ? wst_pkg::ST_IDLE : wst_pkg::ST_LOAD_B;
            end
            wst_pkg::ST_LOAD_B: begin
                state_next = wst_pkg::ST_WALK_B;
            end
            wst_pkg::ST_WALK_B, wst_pkg::ST_WALK_FULL: begin
                if (step && rect_end) state_next = wst_pkg::ST_IDLE;
            end
            default: state_next = wst_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.idle       = 1'b0;
        ctrl.load       = 1'b0;
        ctrl.sel        = wst_pkg::RECT_COLS;
        ctrl.walking    = 1'b0;
        ctrl.final_rect = 1'b0;
        case (state_reg)
            wst_pkg::ST_IDLE: begin
                ctrl.idle = 1'b1;
            end
            wst_pkg::ST_LOAD_A: begin
                if (!near) begin
                    ctrl.load = 1'b1;
                    ctrl.sel  = wst_pkg::RECT_FULL;
                end else if (!dx_zero) begin
                    ctrl.load = 1'b1;
                    ctrl.sel  = wst_pkg::RECT_COLS;
                end else if (!dz_zero) begin
                    ctrl.load = 1'b1;
                    ctrl.sel  = wst_pkg::RECT_ROWS;
                end
            end
            wst_pkg::ST_LOAD_B: begin
                ctrl.load = 1'b1;
                ctrl.sel  = wst_pkg::RECT_ROWS;
            end
            wst_pkg::ST_WALK_A: begin
                ctrl.walking    = 1'b1;
                ctrl.final_rect = dz_zero;
            end
            wst_pkg::ST_WALK_B, wst_pkg::ST_WALK_FULL: begin
                ctrl.walking    = 1'b1;
                ctrl.final_rect = 1'b1;
            end
            default: ctrl.idle = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wst_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/window_shift_tile_enumerator_top.sv]
// The request is registered, then the centre offsets; the walker is loaded next and each
// walked tile is registered at the output. A new request is taken only in idle, after the
// last tile is walked. A near move exposing both columns and rows walks two rectangles
// with a load between them; an unchanged centre emits no tile. The walker emits one tile
// per cycle while the output is not held off, via its single shared 16-bit incrementer.
// Reset: aresetn synchronous, active low; clears the sequencer and output valid.
module window_shift_tile_enumerator_top #(
    parameter int HALF_WIDTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_old_centre_x,
    input  logic [15:0] s_old_centre_z,
    input  logic [15:0] s_new_centre_x,
    input  logic [15:0] s_new_centre_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_tile_x,
    output logic [15:0] m_tile_z,
    output logic        m_last
);

    localparam int            CW    = $clog2(2 * HALF_WIDTH + 1);
    localparam logic [15:0]   R16   = 16'(HALF_WIDTH);
    localparam logic [16:0]   R17   = 17'(HALF_WIDTH);
    localparam logic [CW-1:0] TWO_R = CW'(2 * HALF_WIDTH);

    wst_pkg::ctrl_t ctrl;

    logic [15:0] ox_reg, oz_reg, nx_reg, nz_reg;
    logic signed [16:0] dx_reg, dx_next;
    logic signed [16:0] dz_reg, dz_next;

    logic [16:0]   adx, adz;
    logic          near, dx_zero, dz_zero, dx_pos, dz_pos;
    logic          walk_step, rect_end;
    logic          x_outer;
    logic [15:0]   outer_start, inner_start;
    logic [CW-1:0] outer_len, inner_len;
    logic [15:0]   walk_x, walk_z;

    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_tile_x_reg, m_tile_x_next;
    logic [15:0] m_tile_z_reg, m_tile_z_next;
    logic        m_last_reg, m_last_next;

    assign s_ready = ctrl.idle;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ox_reg <= s_old_centre_x;
            oz_reg <= s_old_centre_z;
            nx_reg <= s_new_centre_x;
            nz_reg <= s_new_centre_z;
        end
    end

    always_comb begin
        dx_next = 17'(signed'(nx_reg)) - 17'(signed'(ox_reg));
        dz_next = 17'(signed'(nz_reg)) - 17'(signed'(oz_reg));
    end

    always_ff @(posedge aclk) begin
        dx_reg <= dx_next;
        dz_reg <= dz_next;
    end

    always_comb begin
        adx     = dx_reg[16] ? 17'(-dx_reg) : 17'(dx_reg);
        adz     = dz_reg[16] ? 17'(-dz_reg) : 17'(dz_reg);
        near    = (adx < R17) && (adz < R17);
        dx_zero = (dx_reg == '0);
        dz_zero = (dz_reg == '0);
        dx_pos  = !dx_reg[16] && !dx_zero;
        dz_pos  = !dz_reg[16] && !dz_zero;
    end

    // rectangle selection for the walker
    always_comb begin
        x_outer     = 1'b1;
        outer_start = dx_pos ? ox_reg + R16 : nx_reg - R16;
        outer_len   = adx[CW-1:0];
        inner_start = nz_reg - R16;
        inner_len   = TWO_R;
        case (ctrl.sel)
            wst_pkg::RECT_COLS: begin
                x_outer = 1'b1;
            end
            wst_pkg::RECT_ROWS: begin
                // rows only span the x range shared by old and new windows
                outer_start = dx_pos ? nx_reg - R16 : ox_reg - R16;
                outer_len   = TWO_R - adx[CW-1:0];
                inner_start = dz_pos ? oz_reg + R16 : nz_reg - R16;
                inner_len   = adz[CW-1:0];
            end
            wst_pkg::RECT_FULL: begin
                x_outer     = 1'b0;
                outer_start = nz_reg - R16;
                outer_len   = TWO_R;
                inner_start = nx_reg - R16;
                inner_len   = TWO_R;
            end
            default: x_outer = 1'b1;
        endcase
    end

    assign walk_step = ctrl.walking && (!m_valid_reg || m_ready);

    wst_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_valid && s_ready),
        .near     (near),
        .dx_zero  (dx_zero),
        .dz_zero  (dz_zero),
        .step     (walk_step),
        .rect_end (rect_end),
        .ctrl     (ctrl)
    );

    wst_walk #(
        .CW (CW)
    ) u_walk (
        .aclk        (aclk),
        .load        (ctrl.load),
        .step        (walk_step),
        .x_outer     (x_outer),
        .outer_start (outer_start),
        .outer_len   (outer_len),
        .inner_start (inner_start),
        .inner_len   (inner_len),
        .tile_x      (walk_x),
        .tile_z      (walk_z),
        .rect_end    (rect_end)
    );

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_tile_x_next = m_tile_x_reg;
        m_tile_z_next = m_tile_z_reg;
        m_last_next   = m_last_reg;
        if (walk_step) begin
            m_valid_next  = 1'b1;
            m_tile_x_next = walk_x;
            m_tile_z_next = walk_z;
            m_last_next   = rect_end && ctrl.final_rect;
        end else if (m_ready) begin
            m_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_tile_x_reg <= m_tile_x_next;
        m_tile_z_reg <= m_tile_z_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_tile_x = m_tile_x_reg;
    assign m_tile_z = m_tile_z_reg;
    assign m_last   = m_last_reg;

    a_step_only_walking: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_step |-> ctrl.walking && !ctrl.idle)
        else $error("walker stepped outside a walk state");

    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after a request was taken");

    a_last_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_step && rect_end && ctrl.final_rect |=> m_valid && m_last)
        else $error("final tile not flagged last");

    a_no_last_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_step && !rect_end |=> m_valid && !m_last)
        else $error("last flagged before end of run");

endmodule

[tb/tb_window_shift_tile_enumerator_top.sv]
`default_nettype none

module tb_window_shift_tile_enumerator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_WIDTH = 4;
    localparam int CENTRE_MAX = 32000;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_HOLD_CYCLES = 400;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] z;
        logic        last;
    } tile_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_old_centre_x;
    logic [15:0] s_old_centre_z;
    logic [15:0] s_new_centre_x;
    logic [15:0] s_new_centre_z;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_tile_x;
    logic [15:0] m_tile_z;
    logic        m_last;

    tile_t pending_tiles[$];
    tile_t head_tile;
    int    errors = 0;
    int    cycle_count = 0;
    int    moves_sent = 0;
    int    near_moves = 0;
    int    far_moves = 0;
    int    still_moves = 0;
    int    tiles_checked = 0;
    int    ready_hold_len = 0;
    bit    calm = 1'b0;

    window_shift_tile_enumerator_top #(
        .HALF_WIDTH(HALF_WIDTH)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_old_centre_x(s_old_centre_x),
        .s_old_centre_z(s_old_centre_z),
        .s_new_centre_x(s_new_centre_x),
        .s_new_centre_z(s_new_centre_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tile_x      (m_tile_x),
        .m_tile_z      (m_tile_z),
        .m_last        (m_last)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d tiles outstanding", $time, pending_tiles.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // x outer, z inner over [x0,x1) x [z0,z1)
    task automatic add_rect(input int x0, x1, z0, z1, ref tile_t run[$]);
        tile_t t;
        for (int x = x0; x < x1; x++) begin
            for (int z = z0; z < z1; z++) begin
                t.x = 16'(x);
                t.z = 16'(z);
                t.last = 1'b0;
                run.push_back(t);
            end
        end
    endtask

    task automatic predict_exposed_tiles(input int ox, oz, nx, nz);
        tile_t run[$];
        tile_t t;
        int dx;
        int dz;
        int xs0;
        int xs1;
        dx = nx - ox;
        dz = nz - oz;
        if (dx > -HALF_WIDTH && dx < HALF_WIDTH && dz > -HALF_WIDTH && dz < HALF_WIDTH) begin
            if (nx > ox) begin
                add_rect(ox + HALF_WIDTH, nx + HALF_WIDTH, nz - HALF_WIDTH, nz + HALF_WIDTH,
                         run);
                xs0 = nx - HALF_WIDTH;
                xs1 = ox + HALF_WIDTH;
            end else begin
                add_rect(nx - HALF_WIDTH, ox - HALF_WIDTH, nz - HALF_WIDTH, nz + HALF_WIDTH,
                         run);
                xs0 = ox - HALF_WIDTH;
                xs1 = nx + HALF_WIDTH;
            end
            if (nz > oz) begin
                add_rect(xs0, xs1, oz + HALF_WIDTH, nz + HALF_WIDTH, run);
            end else begin
                add_rect(xs0, xs1, nz - HALF_WIDTH, oz - HALF_WIDTH, run);
            end
            if (run.size() == 0) begin
                still_moves++;
            end else begin
                near_moves++;
            end
        end else begin
            // whole window, z outer
            for (int z = nz - HALF_WIDTH; z < nz + HALF_WIDTH; z++) begin
                for (int x = nx - HALF_WIDTH; x < nx + HALF_WIDTH; x++) begin
                    t.x = 16'(x);
                    t.z = 16'(z);
                    t.last = 1'b0;
                    run.push_back(t);
                end
            end
            far_moves++;
        end
        if (run.size() > 0) begin
            run[run.size() - 1].last = 1'b1;
        end
        foreach (run[i]) begin
            pending_tiles.push_back(run[i]);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_tiles.size() == 0) begin
                $display("%0t: unexpected tile x=%0d z=%0d last=%0b", $time,
                         $signed(m_tile_x), $signed(m_tile_z), m_last);
                errors++;
            end else begin
                head_tile = pending_tiles.pop_front();
                tiles_checked++;
                if (m_tile_x !== head_tile.x) begin
                    $display("%0t: tile_x mismatch, expected %0d, got %0d", $time,
                             $signed(head_tile.x), $signed(m_tile_x));
                    errors++;
                end
                if (m_tile_z !== head_tile.z) begin
                    $display("%0t: tile_z mismatch, expected %0d, got %0d", $time,
                             $signed(head_tile.z), $signed(m_tile_z));
                    errors++;
                end
                if (m_last !== head_tile.last) begin
                    $display("%0t: last mismatch, expected %0b, got %0b", $time,
                             head_tile.last, m_last);
                    errors++;
                end
            end
        end
    end

    // output side: random stalls, free-running stretches, or a requested long hold
    initial begin
        m_ready = 1'b0;
        forever begin
            if (ready_hold_len > 0) begin
                m_ready <= 1'b0;
                repeat (ready_hold_len) @(negedge aclk);
                ready_hold_len = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_move(input int ox, oz, nx, nz);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_old_centre_x <= 16'(ox);
        s_old_centre_z <= 16'(oz);
        s_new_centre_x <= 16'(nx);
        s_new_centre_z <= 16'(nz);
        do @(posedge aclk); while (!s_ready);
        predict_exposed_tiles(ox, oz, nx, nz);
        moves_sent++;
        @(negedge aclk);
    endtask

    task automatic idle_sender_until_drained();
        s_valid <= 1'b0;
        while (pending_tiles.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic int clamp_centre(input int v);
        if (v > CENTRE_MAX) return CENTRE_MAX;
        if (v < -CENTRE_MAX) return -CENTRE_MAX;
        return v;
    endfunction

    task automatic rand_move(output int ox, oz, nx, nz);
        int kind;
        int dx;
        int dz;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 7) == 0) begin
            // hug the range limits
            ox = $urandom_range(0, 1) ? CENTRE_MAX - int'($urandom_range(0, 6))
                                      : -CENTRE_MAX + int'($urandom_range(0, 6));
            oz = $urandom_range(0, 1) ? CENTRE_MAX - int'($urandom_range(0, 6))
                                      : -CENTRE_MAX + int'($urandom_range(0, 6));
        end else begin
            ox = int'($urandom_range(0, 2 * CENTRE_MAX)) - CENTRE_MAX;
            oz = int'($urandom_range(0, 2 * CENTRE_MAX)) - CENTRE_MAX;
        end
        dx = int'($urandom_range(0, 6)) - 3;
        dz = int'($urandom_range(0, 6)) - 3;
        if (kind < 55) begin
            // near move, already set
        end else if (kind < 63) begin
            // right at the near/far boundary
            if ($urandom_range(0, 1)) begin
                dx = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(3, 4));
            end else begin
                dz = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(3, 4));
            end
        end else if (kind < 70) begin
            dx = 0;
            dz = 0;
        end else if (kind < 88) begin
            dx = int'($urandom_range(0, 24)) - 12;
            dz = int'($urandom_range(4, 12)) * ($urandom_range(0, 1) ? 1 : -1);
            if ($urandom_range(0, 1)) begin
                kind = dx;
                dx = dz;
                dz = kind;
            end
        end else begin
            dx = int'($urandom_range(0, 2 * CENTRE_MAX)) - CENTRE_MAX - ox;
            dz = int'($urandom_range(0, 2 * CENTRE_MAX)) - CENTRE_MAX - oz;
        end
        nx = clamp_centre(ox + dx);
        nz = clamp_centre(oz + dz);
    endtask

    task automatic test_directed_moves();
        send_move(0, 0, 0, 0);
        send_move(0, 0, 1, 2);
        send_move(10, 10, 7, 8);
        send_move(5, -5, 5, -2);
        send_move(-7, 3, -4, 3);
        send_move(100, 100, 97, 103);
        send_move(0, 0, 4, 0);
        send_move(0, 0, 0, -4);
        send_move(0, 0, -3, -3);
        send_move(-CENTRE_MAX, -CENTRE_MAX, -CENTRE_MAX, -CENTRE_MAX);
        send_move(-CENTRE_MAX, -CENTRE_MAX, -31997, -31999);
        send_move(CENTRE_MAX, CENTRE_MAX, 31997, 31998);
        send_move(-CENTRE_MAX, CENTRE_MAX, CENTRE_MAX, -CENTRE_MAX);
        send_move(CENTRE_MAX, -CENTRE_MAX, -CENTRE_MAX, CENTRE_MAX);
        send_move(1234, -567, 1234, -567);
        send_move(-1, -1, 0, 0);
        send_move(0, 0, -1, 1);
        send_move(50, 50, 50, 46);
        send_move(50, 50, -50, 50);
        send_move(7, 7, 10, 4);
        idle_sender_until_drained();
    endtask

    // output held off while far moves keep coming: block must stall its input
    task automatic test_output_hold();
        ready_hold_len = LONG_HOLD_CYCLES;
        for (int i = 0; i < 6; i++) begin
            send_move(i * 100, -i * 100, i * 100 + 20, -i * 100 - 9);
        end
        idle_sender_until_drained();
    endtask

    task automatic test_random_moves(input int count);
        int ox;
        int oz;
        int nx;
        int nz;
        repeat (count) begin
            rand_move(ox, oz, nx, nz);
            send_move(ox, oz, nx, nz);
            if ($urandom_range(0, 39) == 0) begin
                idle_sender_until_drained();
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_old_centre_x = '0;
        s_old_centre_z = '0;
        s_new_centre_x = '0;
        s_new_centre_z = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_moves();
        test_output_hold();
        test_random_moves(250);
        calm = 1'b1;
        test_random_moves(40);
        idle_sender_until_drained();
        $display("Sent %0d moves: %0d near, %0d far, %0d unchanged; %0d tiles checked.",
                 moves_sent, near_moves, far_moves, still_moves, tiles_checked);
        $display("Included range-edge centres, near/far boundary offsets and a long output hold.");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
